FILE: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Request and status codes, widths, channel words, cell port structs.
// ----------------------------------------------------------------------------
`default_nettype none
package spq_pkg;
	localparam int DEPTH = 16;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	localparam logic [2:0] REQ_INSERT  = 3'd0;
	localparam logic [2:0] REQ_DEQUEUE = 3'd1;
	localparam logic [2:0] REQ_PEEK    = 3'd2;
	localparam logic [2:0] REQ_SEARCH  = 3'd3;
	localparam logic [2:0] REQ_SELECT  = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_NONE     = 3'd4;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] prod_id;
		logic [15:0] quantity;
		logic [19:0] limit;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] out_id;
		logic [15:0] out_quantity;
		logic [4:0]  entry_total;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic        ins;
		logic        deq;
		logic        rot;
		logic [15:0] id;
		logic [15:0] qty;
	} cell_cmd_t;

	typedef struct packed {
		logic        occ;
		logic        gt;
		logic        hit;
		logic [15:0] id;
		logic [15:0] qty;
	} cell_view_t;
endpackage
`default_nettype wire

FILE: hdl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if: valid/ready channel
// Generic payload word with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none
interface spq_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Compares against the broadcast key, shifts on insert/dequeue, rotates on select.
// ----------------------------------------------------------------------------
`default_nettype none
module spq_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire spq_pkg::cell_cmd_t    cmd,
	input  wire spq_pkg::cell_view_t   prev,
	input  wire spq_pkg::cell_view_t   next,
	output spq_pkg::cell_view_t        view
);
	logic        occ_q;
	logic [15:0] id_q, qty_q;

	assign view.occ = occ_q;
	assign view.gt  = occ_q ? (cmd.qty > qty_q) : 1'b1;
	assign view.hit = occ_q && (id_q == cmd.id);
	assign view.id  = id_q;
	assign view.qty = qty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.ins) begin
			if (view.gt) begin
				occ_q <= !prev.gt || prev.occ;
			end
		end else if (cmd.deq || cmd.rot) begin
			occ_q <= next.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (view.gt && !prev.gt) begin
				id_q  <= cmd.id;
				qty_q <= cmd.qty;
			end else if (view.gt) begin
				id_q  <= prev.id;
				qty_q <= prev.qty;
			end
		end else if (cmd.deq || cmd.rot) begin
			id_q  <= next.id;
			qty_q <= next.qty;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: descending-quantity queue in a chain of cells
// Insert, dequeue, peek, search and select over a shifting chain.
// ----------------------------------------------------------------------------
// Insert, dequeue, peek, search: result registered; the next word is accepted
// as the sink takes the result word, and waits while the sink still holds it.
// Select rotates the chain once around, one result word per hit (a none word
// if nothing fits); output stalls hold it; the next word waits for its end.
// Unused codes give no word.
// Reset empties the chain at once (valid bits per cell, no clearing pass).
`default_nettype none
module sorted_priority_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	spq_if.sink       req,
	spq_if.source     rsp
);
	localparam int D = spq_pkg::DEPTH;

	spq_pkg::cell_cmd_t  cmd;
	spq_pkg::cell_view_t view [D];
	spq_pkg::cell_view_t prv [D];
	spq_pkg::cell_view_t nxt [D];

	logic [spq_pkg::CW-1:0] cnt_q;
	logic                   sel_q;
	logic [spq_pkg::IW-1:0] step_q;
	logic [20:0]            tot_q;
	logic [19:0]            lim_q;
	logic                   any_q;
	logic                   ov_q;
	logic [2:0]             ost_q;
	logic [15:0]            oid_q, oqty_q;
	logic                   olast_q;

	logic [2:0]  rq;
	logic        take, slot_free, found, full;
	logic [20:0] sum;
	logic        fit, lastcell;

	assign rq   = req.data.req_type;
	assign slot_free = !ov_q || rsp.ready;
	assign req.ready = !sel_q && slot_free;
	assign take = req.valid && req.ready;
	assign full = (cnt_q == spq_pkg::CW'(D));

	always_comb begin
		found = 1'b0;
		for (int i = 0; i < D; i++) found = found | view[i].hit;
	end

	assign sum      = tot_q + {5'd0, view[0].qty};
	assign fit      = view[0].occ && (sum <= {1'b0, lim_q});
	assign lastcell = (step_q == spq_pkg::IW'(D - 1));

	always_comb begin
		cmd.id  = req.data.prod_id;
		cmd.qty = req.data.quantity;
		cmd.ins = take && rq == spq_pkg::REQ_INSERT && !full;
		cmd.deq = take && rq == spq_pkg::REQ_DEQUEUE && cnt_q != '0;
		cmd.rot = sel_q && slot_free;
	end

	for (genvar g = 0; g < D; g++) begin : g_cell
		if (g == 0) begin : g_f
			assign prv[g] = '0;
		end else begin : g_m
			assign prv[g] = view[g-1];
		end
		if (g == D - 1) begin : g_l
			assign nxt[g] = sel_q ? view[0] : '0;
		end else begin : g_n
			assign nxt[g] = view[g+1];
		end
		spq_cell u_cell (.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.prev(prv[g]), .next(nxt[g]), .view(view[g]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; sel_q <= 1'b0; ov_q <= 1'b0;
			step_q <= '0; any_q <= 1'b0;
		end else begin
			if (take) begin
				unique case (rq) inside
					spq_pkg::REQ_INSERT: begin
						ov_q <= 1'b1;
						if (!full) cnt_q <= cnt_q + 1'b1;
					end
					spq_pkg::REQ_DEQUEUE: begin
						ov_q <= 1'b1;
						if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
					end
					spq_pkg::REQ_PEEK, spq_pkg::REQ_SEARCH: ov_q <= 1'b1;
					spq_pkg::REQ_SELECT: begin
						ov_q <= 1'b0;
						sel_q <= 1'b1; step_q <= '0; any_q <= 1'b0;
					end
					default: ov_q <= 1'b0;
				endcase
			end else if (cmd.rot) begin
				step_q <= step_q + 1'b1;
				if (fit) any_q <= 1'b1;
				ov_q <= fit || (lastcell && !any_q);
				if (lastcell) sel_q <= 1'b0;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tot_q <= '0;
			lim_q <= req.data.limit;
			olast_q <= 1'b1;
			oid_q <= '0; oqty_q <= '0;
			unique case (rq) inside
				spq_pkg::REQ_INSERT: begin
					ost_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
					if (!full) begin
						oid_q <= req.data.prod_id; oqty_q <= req.data.quantity;
					end
				end
				spq_pkg::REQ_DEQUEUE, spq_pkg::REQ_PEEK: begin
					ost_q <= (cnt_q == '0) ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
					if (cnt_q != '0) begin
						oid_q <= view[0].id; oqty_q <= view[0].qty;
					end
				end
				spq_pkg::REQ_SEARCH: begin
					ost_q <= found ? spq_pkg::ST_OK : spq_pkg::ST_NOTFOUND;
					if (found) oid_q <= req.data.prod_id;
				end
				default: ost_q <= spq_pkg::ST_OK;
			endcase
		end else if (cmd.rot) begin
			if (fit) begin
				tot_q <= sum;
				ost_q <= spq_pkg::ST_OK;
				oid_q <= view[0].id; oqty_q <= view[0].qty;
			end else begin
				ost_q <= spq_pkg::ST_NONE;
				oid_q <= '0; oqty_q <= '0;
			end
			olast_q <= 1'b0;
		end
	end

	// last flag for select: a hit is last if nothing later fits
	logic lastfit;
	always_comb begin
		logic [20:0] t;
		t = sum;
		lastfit = 1'b1;
		for (int i = 1; i < D; i++) begin
			if (spq_pkg::IW'(i) > spq_pkg::IW'(D - 1) - step_q) begin
			end else if (view[i].occ && (t + {5'd0, view[i].qty} <= {1'b0, lim_q})) begin
				lastfit = 1'b0;
			end
		end
	end
	logic lastsel_q;
	always_ff @(posedge clk) begin
		if (cmd.rot) lastsel_q <= !fit || lastfit || lastcell;
		else if (take) lastsel_q <= 1'b1;
	end

	assign rsp.valid             = ov_q;
	assign rsp.data.status       = ost_q;
	assign rsp.data.out_id       = oid_q;
	assign rsp.data.out_quantity = oqty_q;
	assign rsp.data.entry_total  = cnt_q;
	assign rsp.data.last         = olast_q | lastsel_q;

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= spq_pkg::CW'(D))
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("output changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> !cmd.deq && !cmd.rot)
		else $error("conflicting chain commands");
endmodule
`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for sorted_priority_queue
// Drives insert, dequeue, peek, search and select words, with bursty input and
// stalling output. A local model of the descending-quantity store predicts
// every result word, and each accepted result is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spq_if #(.T(spq_pkg::req_t)) req_ch ();
	spq_if #(.T(spq_pkg::rsp_t)) rsp_ch ();

	sorted_priority_queue u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// queue contents, front first
	logic [15:0]   q_ids [spq_pkg::DEPTH];
	logic [15:0]   q_qtys [spq_pkg::DEPTH];
	int            q_count = 0;
	spq_pkg::rsp_t expected_words [$];
	int            errors = 0;

	// sender pacing
	int burst_left = 0;
	bit no_gaps = 1'b0;
	// receiver pacing
	int hold_left = 0;
	int rx_mode = 0;
	int rx_cycle = 0;

	function automatic spq_pkg::rsp_t mk(logic [2:0] st, logic [15:0] id,
		logic [15:0] qty, logic lst);
		spq_pkg::rsp_t r;
		r.status = st;
		r.out_id = id;
		r.out_quantity = qty;
		r.entry_total = q_count[4:0];
		r.last = lst;
		return r;
	endfunction

	task automatic predict_queue(spq_pkg::req_t w);
		int pos;
		int n;
		logic [31:0] total;
		bit found;
		spq_pkg::rsp_t tail;
		case (w.req_type)
			spq_pkg::REQ_INSERT: begin
				if (q_count >= spq_pkg::DEPTH) begin
					expected_words.push_back(mk(spq_pkg::ST_FULL, '0, '0, 1'b1));
				end else begin
					pos = q_count;
					for (int i = 0; i < q_count; i++)
						if (w.quantity > q_qtys[i]) begin
							pos = i;
							break;
						end
					for (int i = q_count; i > pos; i--) begin
						q_ids[i] = q_ids[i-1];
						q_qtys[i] = q_qtys[i-1];
					end
					q_ids[pos] = w.prod_id;
					q_qtys[pos] = w.quantity;
					q_count++;
					expected_words.push_back(mk(spq_pkg::ST_OK, w.prod_id, w.quantity, 1'b1));
				end
			end
			spq_pkg::REQ_DEQUEUE, spq_pkg::REQ_PEEK: begin
				if (q_count == 0) begin
					expected_words.push_back(mk(spq_pkg::ST_EMPTY, '0, '0, 1'b1));
				end else begin
					logic [15:0] fid, fq;
					fid = q_ids[0];
					fq = q_qtys[0];
					if (w.req_type == spq_pkg::REQ_DEQUEUE) begin
						for (int i = 0; i + 1 < q_count; i++) begin
							q_ids[i] = q_ids[i+1];
							q_qtys[i] = q_qtys[i+1];
						end
						q_count--;
					end
					expected_words.push_back(mk(spq_pkg::ST_OK, fid, fq, 1'b1));
				end
			end
			spq_pkg::REQ_SEARCH: begin
				found = 1'b0;
				for (int i = 0; i < q_count; i++)
					if (q_ids[i] == w.prod_id)
						found = 1'b1;
				if (found)
					expected_words.push_back(mk(spq_pkg::ST_OK, w.prod_id, '0, 1'b1));
				else
					expected_words.push_back(mk(spq_pkg::ST_NOTFOUND, '0, '0, 1'b1));
			end
			spq_pkg::REQ_SELECT: begin
				total = 0;
				n = 0;
				for (int i = 0; i < q_count && n < spq_pkg::DEPTH; i++)
					if (total + q_qtys[i] <= w.limit) begin
						total += q_qtys[i];
						expected_words.push_back(mk(spq_pkg::ST_OK, q_ids[i], q_qtys[i], 1'b0));
						n++;
					end
				if (n == 0) begin
					expected_words.push_back(mk(spq_pkg::ST_NONE, '0, '0, 1'b1));
				end else begin
					tail = expected_words.pop_back();
					tail.last = 1'b1;
					expected_words.push_back(tail);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			predict_queue(req_ch.data);
	end

	task automatic chk(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		spq_pkg::rsp_t e, a;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			a = rsp_ch.data;
			if (expected_words.size() == 0) begin
				$error("unexpected result word: status %0d id %0d", a.status, a.out_id);
				errors++;
			end else begin
				e = expected_words.pop_front();
				chk("status", e.status, a.status);
				chk("out_id", e.out_id, a.out_id);
				chk("out_quantity", e.out_quantity, a.out_quantity);
				chk("entry_total", e.entry_total, a.entry_total);
				chk("last", e.last, a.last);
			end
		end
	end

	// receiver: long holds, then modes of always ready, random, periodic, sparse
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 97 == 0)
			rx_mode = $urandom_range(0, 3);
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				2: rsp_ch.ready <= (rx_cycle % 4) != 0;
				default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	task automatic send_word(spq_pkg::req_t w);
		@(negedge clk);
		req_ch.data <= w;
		req_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
		if (!no_gaps) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 12);
				@(negedge clk);
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
	endtask

	task automatic go_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	function automatic spq_pkg::req_t word(logic [2:0] t, logic [15:0] id,
		logic [15:0] qty, logic [19:0] lim);
		spq_pkg::req_t w;
		w.req_type = t;
		w.prod_id = id;
		w.quantity = qty;
		w.limit = lim;
		return w;
	endfunction

	function automatic spq_pkg::req_t rand_word();
		int pick;
		logic [15:0] id;
		logic [15:0] qty;
		logic [19:0] lim;
		pick = $urandom_range(0, 99);
		id = 16'($urandom);
		qty = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
		case ($urandom_range(0, 3))
			0: lim = 20'($urandom);
			1: lim = 20'($urandom_range(0, 70000));
			2: lim = 20'hFFFFF;
			default: lim = 20'($urandom_range(0, 300000));
		endcase
		if (q_count > 0 && $urandom_range(0, 1))
			id = q_ids[$urandom_range(0, q_count - 1)];
		if (pick < 38) return word(spq_pkg::REQ_INSERT, id, qty, lim);
		if (pick < 58) return word(spq_pkg::REQ_DEQUEUE, id, qty, lim);
		if (pick < 68) return word(spq_pkg::REQ_PEEK, id, qty, lim);
		if (pick < 80) return word(spq_pkg::REQ_SEARCH, id, qty, lim);
		if (pick < 97) return word(spq_pkg::REQ_SELECT, id, qty, lim);
		return word(3'($urandom_range(5, 7)), id, qty, lim);
	endfunction

	task automatic drain_wait();
		go_idle();
		wait (expected_words.size() == 0);
		repeat (spq_pkg::DEPTH + 8) @(posedge clk);
	endtask

	task automatic test_directed();
		send_word(word(spq_pkg::REQ_DEQUEUE, 16'hFFFF, 16'hFFFF, 20'hFFFFF));
		send_word(word(spq_pkg::REQ_PEEK, 16'h0, 16'h0, 20'h0));
		send_word(word(spq_pkg::REQ_SEARCH, 16'h1234, 16'h0, 20'h0));
		send_word(word(spq_pkg::REQ_SELECT, 16'h0, 16'h0, 20'hFFFFF));
		send_word(word(3'd5, 16'hFFFF, 16'hFFFF, 20'hFFFFF));
		send_word(word(spq_pkg::REQ_INSERT, 16'hFFFF, 16'hFFFF, 20'h0));
		send_word(word(spq_pkg::REQ_INSERT, 16'h0000, 16'h0000, 20'hFFFFF));
		send_word(word(spq_pkg::REQ_INSERT, 16'h0011, 16'h0100, 20'h0));
		send_word(word(spq_pkg::REQ_INSERT, 16'h0022, 16'h0100, 20'h0));
		send_word(word(3'd6, 16'h0, 16'h0, 20'h0));
		send_word(word(3'd7, 16'h0, 16'h0, 20'h0));
		send_word(word(spq_pkg::REQ_PEEK, 16'h0, 16'h0, 20'h0));
		send_word(word(spq_pkg::REQ_SEARCH, 16'h0000, 16'h0, 20'h0));
		send_word(word(spq_pkg::REQ_SEARCH, 16'h0022, 16'h0, 20'h0));
		send_word(word(spq_pkg::REQ_SEARCH, 16'h0033, 16'h0, 20'h0));
		send_word(word(spq_pkg::REQ_SELECT, 16'h0, 16'h0, 20'h0));
		send_word(word(spq_pkg::REQ_SELECT, 16'h0, 16'h0, 20'h00100));
		send_word(word(spq_pkg::REQ_SELECT, 16'h0, 16'h0, 20'hFFFFF));
		send_word(word(spq_pkg::REQ_DEQUEUE, 16'h0, 16'h0, 20'h0));
		send_word(word(spq_pkg::REQ_SELECT, 16'h0, 16'h0, 20'h000FF));
		drain_wait();
	endtask

	task automatic test_fill_and_cap();
		no_gaps = 1'b1;
		while (q_count < spq_pkg::DEPTH)
			send_word(word(spq_pkg::REQ_INSERT, 16'($urandom),
				16'($urandom_range(0, 65535)), '0));
		send_word(word(spq_pkg::REQ_INSERT, 16'hBEEF, 16'hFFFF, '0));
		send_word(word(spq_pkg::REQ_SELECT, '0, '0, 20'hFFFFF));
		send_word(word(spq_pkg::REQ_SEARCH, q_ids[spq_pkg::DEPTH-1], '0, '0));
		no_gaps = 1'b0;
		drain_wait();
	endtask

	task automatic test_backpressure();
		hold_left = 400;
		for (int i = 0; i < 20; i++)
			send_word(word(spq_pkg::REQ_SELECT, '0, '0, 20'hFFFFF));
		drain_wait();
		while (q_count > 0)
			send_word(word(spq_pkg::REQ_DEQUEUE, '0, '0, '0));
		send_word(word(spq_pkg::REQ_DEQUEUE, '0, '0, '0));
		drain_wait();
	endtask

	task automatic test_random();
		for (int i = 0; i < 400; i++) begin
			no_gaps = (i >= 150 && i < 200);
			send_word(rand_word());
			if (i == 300) begin
				go_idle();
				wait (expected_words.size() == 0);
			end
		end
		no_gaps = 1'b0;
		drain_wait();
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_fill_and_cap();
		test_backpressure();
		test_random();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
